// File: src/pfc_pkg.sv
`default_nettype none

package pfc_pkg;

  // array size and queue depth defaults
  localparam int unsigned ARRAY_BYTES_DEF = 32768;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned TICKS_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS  = 2'd2;
  localparam logic [TICKS_W-1:0]   TICKS_RST  = 16'd20;

  // bus command codes
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // unlock addresses and command bytes
  localparam logic [ADDR_W-1:0] ADDR_A          = 15'h5555;
  localparam logic [ADDR_W-1:0] ADDR_B          = 15'h2AAA;
  localparam logic [DATA_W-1:0] DAT_UNLOCK_1    = 8'hAA;
  localparam logic [DATA_W-1:0] DAT_UNLOCK_2    = 8'h55;
  localparam logic [DATA_W-1:0] DAT_ERASE_SETUP = 8'h80;
  localparam logic [DATA_W-1:0] DAT_CHIP_ERASE  = 8'h10;
  localparam logic [DATA_W-1:0] DAT_PROGRAM     = 8'hA0;
  localparam logic [DATA_W-1:0] DAT_ID_ENTRY    = 8'h90;
  localparam logic [DATA_W-1:0] DAT_ID_EXIT     = 8'hF0;
  localparam logic [DATA_W-1:0] DAT_ERASED      = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ,
    OP_WRITE,
    OP_TICK,
    OP_NOP
  } op_kind_e;

  typedef enum logic [2:0] {
    WC_UNLOCK_1,
    WC_UNLOCK_2,
    WC_ERASE_SETUP,
    WC_CHIP_ERASE,
    WC_PROGRAM,
    WC_ID_ENTRY,
    WC_ID_EXIT,
    WC_OTHER
  } wcode_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_AA,
    SEQ_55,
    SEQ_PROG,
    SEQ_E80,
    SEQ_EAA,
    SEQ_E55
  } seq_e;

  typedef enum logic [1:0] {
    BK_INIT,
    BK_RUN,
    BK_READ,
    BK_PROG
  } bk_state_e;

  // classified bus beat handed from front to back
  typedef struct packed {
    op_kind_e          kind;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              addr_a;
    logic              addr_b;
    wcode_e            code;
  } op_t;

  // result beat
  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              busy;
  } res_t;

  // back status seen by the front
  typedef struct packed {
    logic init_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: src/pfc_fifo.sv
`default_nettype none

module pfc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = pfc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: src/pfc_front.sv
`default_nettype none

module pfc_front (
  input  wire logic                         push_i,
  output logic                              full_o,
  input  wire logic [pfc_pkg::CMD_W-1:0]    command_i,
  input  wire logic [pfc_pkg::ADDR_W-1:0]   address_i,
  input  wire logic [pfc_pkg::DATA_W-1:0]   write_data_i,
  input  wire pfc_pkg::stat_t               stat_i,
  input  wire logic                         queue_full_i,
  output logic                              op_push_o,
  output pfc_pkg::op_t                      op_o
);

  pfc_pkg::op_kind_e kind;
  pfc_pkg::wcode_e   code;

  // no beat taken while the array is cleared after reset or the queue is full
  assign full_o    = queue_full_i || stat_i.init_busy;
  assign op_push_o = push_i && !full_o;

  // command decode
  always_comb begin
    unique case (command_i)
      pfc_pkg::CMD_READ:  kind = pfc_pkg::OP_READ;
      pfc_pkg::CMD_WRITE: kind = pfc_pkg::OP_WRITE;
      pfc_pkg::CMD_TICK:  kind = pfc_pkg::OP_TICK;
      default:            kind = pfc_pkg::OP_NOP;
    endcase
  end

  // write data classification
  always_comb begin
    unique case (write_data_i)
      pfc_pkg::DAT_UNLOCK_1:    code = pfc_pkg::WC_UNLOCK_1;
      pfc_pkg::DAT_UNLOCK_2:    code = pfc_pkg::WC_UNLOCK_2;
      pfc_pkg::DAT_ERASE_SETUP: code = pfc_pkg::WC_ERASE_SETUP;
      pfc_pkg::DAT_CHIP_ERASE:  code = pfc_pkg::WC_CHIP_ERASE;
      pfc_pkg::DAT_PROGRAM:     code = pfc_pkg::WC_PROGRAM;
      pfc_pkg::DAT_ID_ENTRY:    code = pfc_pkg::WC_ID_ENTRY;
      pfc_pkg::DAT_ID_EXIT:     code = pfc_pkg::WC_ID_EXIT;
      default:                  code = pfc_pkg::WC_OTHER;
    endcase
  end

  // queued beat
  always_comb begin
    op_o.kind   = kind;
    op_o.addr   = address_i;
    op_o.data   = write_data_i;
    op_o.addr_a = (address_i == pfc_pkg::ADDR_A);
    op_o.addr_b = (address_i == pfc_pkg::ADDR_B);
    op_o.code   = code;
  end

endmodule

`default_nettype wire

// File: src/pfc_back.sv
`default_nettype none

module pfc_back #(
  parameter int unsigned ARRAY_BYTES = pfc_pkg::ARRAY_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            op_valid_i,
  input  wire pfc_pkg::op_t                    op_i,
  output logic                                 op_pop_o,
  input  wire logic                            res_full_i,
  output logic                                 res_push_o,
  output pfc_pkg::res_t                        res_o,
  output pfc_pkg::stat_t                       stat_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(ARRAY_BYTES);
  localparam logic [AW-1:0] PTR_LAST = AW'(ARRAY_BYTES - 1);
  localparam int unsigned DW = pfc_pkg::DATA_W;
  localparam int unsigned TW = pfc_pkg::TICKS_W;

  // flash array
  logic [DW-1:0] mem_q [ARRAY_BYTES];
  logic [DW-1:0] mem_rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [DW-1:0] mem_wd;

  // control state
  pfc_pkg::bk_state_e state_q, state_d;
  pfc_pkg::seq_e      seq_q, seq_d;
  logic               id_mode_q, id_mode_d;
  logic [TW-1:0]      busy_cnt_q, busy_cnt_d;
  logic               erasing_q, erasing_d;
  logic [AW-1:0]      erase_ptr_q, erase_ptr_d;
  logic [pfc_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic [DW-1:0]      pend_data_q, pend_data_d;

  // configuration registers
  logic [DW-1:0] manuf_q, manuf_d;
  logic [DW-1:0] device_q, device_d;
  logic [TW-1:0] ticks_q, ticks_d;

  logic take, busy, prog_busy, id_hit, last_tick, ptr_last;

  assign busy      = (busy_cnt_q != '0) || erasing_q;
  assign prog_busy = (busy_cnt_q != '0);
  assign take      = (state_q == pfc_pkg::BK_RUN) && op_valid_i && !res_full_i;
  assign id_hit    = id_mode_q && (op_i.addr[pfc_pkg::ADDR_W-1:1] == '0);
  assign last_tick = (busy_cnt_q == TW'(1));
  assign ptr_last  = (erase_ptr_q == PTR_LAST);
  assign op_pop_o  = take;
  assign stat_o.init_busy = (state_q == pfc_pkg::BK_INIT);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfc_pkg::BK_INIT: begin
        if (ptr_last) begin
          state_d = pfc_pkg::BK_RUN;
        end
      end
      pfc_pkg::BK_RUN: begin
        if (take && op_i.kind == pfc_pkg::OP_READ && !busy && !id_hit) begin
          state_d = pfc_pkg::BK_READ;
        end else if (take && op_i.kind == pfc_pkg::OP_TICK && last_tick) begin
          state_d = pfc_pkg::BK_PROG;
        end
      end
      pfc_pkg::BK_READ: state_d = pfc_pkg::BK_RUN;
      pfc_pkg::BK_PROG: state_d = pfc_pkg::BK_RUN;
      default:          state_d = pfc_pkg::BK_RUN;
    endcase
  end

  // datapath and outputs
  always_comb begin
    seq_d       = seq_q;
    id_mode_d   = id_mode_q;
    busy_cnt_d  = busy_cnt_q;
    erasing_d   = erasing_q;
    erase_ptr_d = erase_ptr_q;
    pend_addr_d = pend_addr_q;
    pend_data_d = pend_data_q;
    mem_we      = 1'b0;
    mem_wa      = erase_ptr_q;
    mem_wd      = pfc_pkg::DAT_ERASED;
    mem_re      = 1'b0;
    mem_ra      = AW'(op_i.addr);
    res_push_o  = 1'b0;
    res_o.rdata = '0;
    res_o.busy  = busy;

    unique case (state_q)
      // clearing sweep after reset
      pfc_pkg::BK_INIT: begin
        mem_we      = 1'b1;
        erase_ptr_d = ptr_last ? '0 : erase_ptr_q + 1'b1;
      end

      pfc_pkg::BK_RUN: begin
        if (take) begin
          case (op_i.kind)
            pfc_pkg::OP_READ: begin
              if (prog_busy) begin
                res_push_o  = 1'b1;
                res_o.rdata = {~pend_data_q[DW-1], {(DW-1){1'b0}}};
              end else if (erasing_q) begin
                res_push_o = 1'b1;
              end else if (id_hit) begin
                res_push_o  = 1'b1;
                res_o.rdata = op_i.addr[0] ? device_q : manuf_q;
              end else begin
                mem_re = 1'b1;
              end
            end

            pfc_pkg::OP_WRITE: begin
              res_push_o = 1'b1;
              if (!busy) begin
                seq_d = pfc_pkg::SEQ_IDLE;
                unique case (seq_q)
                  pfc_pkg::SEQ_IDLE: begin
                    if (op_i.addr_a && op_i.code == pfc_pkg::WC_UNLOCK_1) begin
                      seq_d = pfc_pkg::SEQ_AA;
                    end
                  end
                  pfc_pkg::SEQ_AA: begin
                    if (op_i.addr_b && op_i.code == pfc_pkg::WC_UNLOCK_2) begin
                      seq_d = pfc_pkg::SEQ_55;
                    end
                  end
                  pfc_pkg::SEQ_55: begin
                    if (op_i.addr_a) begin
                      case (op_i.code)
                        pfc_pkg::WC_PROGRAM:     seq_d = pfc_pkg::SEQ_PROG;
                        pfc_pkg::WC_ERASE_SETUP: seq_d = pfc_pkg::SEQ_E80;
                        pfc_pkg::WC_ID_ENTRY:    id_mode_d = 1'b1;
                        pfc_pkg::WC_ID_EXIT:     id_mode_d = 1'b0;
                        default:                 seq_d = pfc_pkg::SEQ_IDLE;
                      endcase
                    end
                  end
                  pfc_pkg::SEQ_PROG: begin
                    pend_addr_d = op_i.addr;
                    pend_data_d = op_i.data;
                    busy_cnt_d  = (ticks_q != '0) ? ticks_q : TW'(1);
                    res_o.busy  = 1'b1;
                  end
                  pfc_pkg::SEQ_E80: begin
                    if (op_i.addr_a && op_i.code == pfc_pkg::WC_UNLOCK_1) begin
                      seq_d = pfc_pkg::SEQ_EAA;
                    end
                  end
                  pfc_pkg::SEQ_EAA: begin
                    if (op_i.addr_b && op_i.code == pfc_pkg::WC_UNLOCK_2) begin
                      seq_d = pfc_pkg::SEQ_E55;
                    end
                  end
                  pfc_pkg::SEQ_E55: begin
                    if (op_i.addr_a && op_i.code == pfc_pkg::WC_CHIP_ERASE) begin
                      erasing_d   = 1'b1;
                      erase_ptr_d = '0;
                      res_o.busy  = 1'b1;
                    end
                  end
                  default: seq_d = pfc_pkg::SEQ_IDLE;
                endcase
              end
            end

            pfc_pkg::OP_TICK: begin
              res_push_o = 1'b1;
              if (prog_busy) begin
                busy_cnt_d = busy_cnt_q - 1'b1;
                res_o.busy = !last_tick;
                if (last_tick) begin
                  // fetch the target byte for the and-merge
                  mem_re = 1'b1;
                  mem_ra = AW'(pend_addr_q);
                end
              end else if (erasing_q) begin
                mem_we      = 1'b1;
                erase_ptr_d = ptr_last ? '0 : erase_ptr_q + 1'b1;
                erasing_d   = !ptr_last;
                res_o.busy  = !ptr_last;
              end
            end

            default: begin
              res_push_o = 1'b1;
            end
          endcase
        end
      end

      // array read data arrives
      pfc_pkg::BK_READ: begin
        res_push_o  = 1'b1;
        res_o.rdata = mem_rdata_q;
        res_o.busy  = 1'b0;
      end

      // program completes: and the byte into the array
      pfc_pkg::BK_PROG: begin
        mem_we = 1'b1;
        mem_wa = AW'(pend_addr_q);
        mem_wd = mem_rdata_q & pend_data_q;
      end

      default: begin
      end
    endcase
  end

  // configuration writes
  always_comb begin
    manuf_d  = manuf_q;
    device_d = device_q;
    ticks_d  = ticks_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfc_pkg::CFG_MANUF:  manuf_d  = cfg_wdata_i[DW-1:0];
        pfc_pkg::CFG_DEVICE: device_d = cfg_wdata_i[DW-1:0];
        pfc_pkg::CFG_TICKS:  ticks_d  = cfg_wdata_i[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfc_pkg::BK_INIT;
      seq_q       <= pfc_pkg::SEQ_IDLE;
      id_mode_q   <= 1'b0;
      busy_cnt_q  <= '0;
      erasing_q   <= 1'b0;
      erase_ptr_q <= '0;
      pend_addr_q <= '0;
      pend_data_q <= '0;
      manuf_q     <= '0;
      device_q    <= '0;
      ticks_q     <= pfc_pkg::TICKS_RST;
    end else begin
      state_q     <= state_d;
      seq_q       <= seq_d;
      id_mode_q   <= id_mode_d;
      busy_cnt_q  <= busy_cnt_d;
      erasing_q   <= erasing_d;
      erase_ptr_q <= erase_ptr_d;
      pend_addr_q <= pend_addr_d;
      pend_data_q <= pend_data_d;
      manuf_q     <= manuf_d;
      device_q    <= device_d;
      ticks_q     <= ticks_d;
    end
  end

  // array port: one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_ra];
    end
  end

endmodule

`default_nettype wire

// File: src/parallel_flash_command_fsm_top.sv
`default_nettype none

// Byte-wide parallel flash with software command sequences.
// Input channel (push/full): one bus beat per accepted push, a read, a write,
// a time tick or a no-op, with its address and write data.
// Result channel (empty/pop): one beat per input beat, in order, carrying
// read_data_o and busy_res_o.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 manufacturer code, 1 device code, 2 program ticks), registered.
// Path: every beat passes the command queue and the result queue; array reads
// also pass the registered array read. Throughput: one beat per cycle while the
// result queue has room, except an array read or the tick that completes a
// program (one read, then the write), which pass BK_READ or BK_PROG as well.
// Reset: the array is cleared to FF by a sweep over all ARRAY_BYTES bytes (32768
// at the default) after reset is released; full stays high meanwhile.
// Stalls: a two-beat queue sits on each side of the execute stage; when
// pop is held low the result queue fills, execution halts and full rises
// once the command queue is full as well.
module parallel_flash_command_fsm_top #(
  parameter int unsigned ARRAY_BYTES = pfc_pkg::ARRAY_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [pfc_pkg::CMD_W-1:0]       command_i,
  input  wire logic [pfc_pkg::ADDR_W-1:0]      address_i,
  input  wire logic [pfc_pkg::DATA_W-1:0]      write_data_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic      [pfc_pkg::DATA_W-1:0]      read_data_o,
  output logic                                 busy_res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  pfc_pkg::stat_t stat;
  pfc_pkg::op_t   op_in, op_out;
  pfc_pkg::res_t  res_in, res_out;
  logic           op_push, op_pop, op_full, op_empty;
  logic           res_push, res_full;

  // front: accept and classify
  pfc_front u_front (
    .push_i       (push),
    .full_o       (full),
    .command_i    (command_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .stat_i       (stat),
    .queue_full_i (op_full),
    .op_push_o    (op_push),
    .op_o         (op_in)
  );

  // command queue
  pfc_fifo #(
    .WIDTH ($bits(pfc_pkg::op_t)),
    .DEPTH (pfc_pkg::QUEUE_DEPTH)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .data_o  (op_out),
    .empty_o (op_empty)
  );

  // back: execute against the array
  pfc_back #(
    .ARRAY_BYTES (ARRAY_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // result queue
  pfc_fifo #(
    .WIDTH ($bits(pfc_pkg::res_t)),
    .DEPTH (pfc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign read_data_o = res_out.rdata;
  assign busy_res_o  = res_out.busy;

endmodule

`default_nettype wire

// File: src/pfc_checker.sv
`default_nettype none

module pfc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        full,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic [pfc_pkg::DATA_W-1:0]  read_data_o,
  input wire logic                        busy_res_o
);

  // a waiting result holds until popped
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(read_data_o) && $stable(busy_res_o)))
    else $error("result changed while stalled");

  // while busy only the polling bit can be set
  a_busy_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && busy_res_o) |-> (read_data_o[pfc_pkg::DATA_W-2:0] == '0))
    else $error("busy result carries data bits");

  // no beat is taken in reset or as it is released (array sweep)
  a_full_reset: assert property (@(posedge clk_i)
    (!rst_ni || $rose(rst_ni)) |-> full)
    else $error("input open during reset");

  // no result during reset
  a_empty_reset: assert property (@(posedge clk_i)
    !rst_ni |-> empty)
    else $error("result shown during reset");

endmodule

bind parallel_flash_command_fsm_top pfc_checker u_pfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .read_data_o (read_data_o),
  .busy_res_o  (busy_res_o)
);

`default_nettype wire
